// ===== hw/rtl/ttip_pkg.sv =====
// ----------------------------------------------------------------------------
// ttip_pkg - shared types and constants of the text-to-integer parser
// Character classes, parser phases, step actions, status and register codes.
// ----------------------------------------------------------------------------
package ttip_pkg;

	// register indexes on the write port
	localparam logic REG_RADIX = 1'b0;
	localparam logic REG_KIND  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_U32 = 2'd0;
	localparam logic [1:0] KIND_U64 = 2'd1;
	localparam logic [1:0] KIND_S64 = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_DIGITS = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_BAD_BASE  = 2'd3;

	// bases
	localparam logic [5:0] MAX_BASE = 6'd36;
	localparam logic [5:0] BASE_AUTO = 6'd0;
	localparam logic [5:0] BASE_ONE = 6'd1;
	localparam logic [5:0] BASE_OCT = 6'd8;
	localparam logic [5:0] BASE_DEC = 6'd10;
	localparam logic [5:0] BASE_HEX = 6'd16;
	localparam logic [5:0] RADIX_RESET = BASE_DEC;

	// digit codes: 'x'/'X' decode to 33, anything that is no digit to 63
	localparam logic [5:0] DIGIT_ZERO = 6'd0;
	localparam logic [5:0] DIGIT_X    = 6'd33;
	localparam logic [5:0] DIGIT_NONE = 6'd63;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] ALPHA_OFS = 8'd10;

	// limits
	localparam logic [63:0] LIM_U32 = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] LIM_U64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		PH_DONE   = 3'd0,
		PH_LEAD   = 3'd1,
		PH_SIGNED = 3'd2,
		PH_ZERO   = 3'd3,
		PH_AFTERX = 3'd4,
		PH_DIGITS = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		ACT_IGNORE,
		ACT_ADVANCE,
		ACT_SIGN,
		ACT_ZERO,
		ACT_PREFIX,
		ACT_DIGIT,
		ACT_FIN_POS,
		ACT_FIN_MARK,
		ACT_BAD_BASE
	} act_t;

	// one classified character beat
	typedef struct packed {
		logic       begin_req;
		logic       space;
		logic       plus;
		logic       minus;
		logic [5:0] digit;
	} chr_class_t;

	// configuration registers
	typedef struct packed {
		logic [5:0] radix;
		logic [1:0] kind;
	} cfg_t;

endpackage

// ===== hw/rtl/ttip_front.sv =====
// ----------------------------------------------------------------------------
// ttip_front - character classifier
// Decodes each accepted byte into space, sign and digit value for the back end.
// ----------------------------------------------------------------------------
module ttip_front (
	input  logic                  begin_req,
	input  logic [7:0]            chr,
	output ttip_pkg::chr_class_t  cls
);

	logic [7:0] dig8;

	// digit value, DIGIT_NONE for anything that is no digit
	always_comb begin
		dig8 = {2'b00, ttip_pkg::DIGIT_NONE};
		if (chr >= ttip_pkg::CH_0 && chr <= ttip_pkg::CH_9) begin
			dig8 = chr - ttip_pkg::CH_0;
		end else if (chr >= ttip_pkg::CH_UA && chr <= ttip_pkg::CH_UZ) begin
			dig8 = chr - ttip_pkg::CH_UA + ttip_pkg::ALPHA_OFS;
		end else if (chr >= ttip_pkg::CH_LA && chr <= ttip_pkg::CH_LZ) begin
			dig8 = chr - ttip_pkg::CH_LA + ttip_pkg::ALPHA_OFS;
		end
	end

	// pack the class
	always_comb begin
		cls.begin_req = begin_req;
		cls.space     = (chr == ttip_pkg::CH_SPACE) ||
		                (chr >= ttip_pkg::CH_TAB && chr <= ttip_pkg::CH_CR);
		cls.plus      = (chr == ttip_pkg::CH_PLUS);
		cls.minus     = (chr == ttip_pkg::CH_MINUS);
		cls.digit     = dig8[5:0];
	end

endmodule

// ===== hw/rtl/ttip_queue.sv =====
// ----------------------------------------------------------------------------
// ttip_queue - two-entry queue between classifier and parser back end
// Registered storage; takes a beat whenever it is not full.
// ----------------------------------------------------------------------------
module ttip_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ttip_pkg::chr_class_t  push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output ttip_pkg::chr_class_t  head
);

	ttip_pkg::chr_class_t ent_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = ent_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== hw/rtl/ttip_back.sv =====
// ----------------------------------------------------------------------------
// ttip_back - parser state machine and accumulator
// Steps one beat per cycle unless stalled; holds the result in an output register.
// ----------------------------------------------------------------------------
module ttip_back #(
	parameter int OFFSET_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ttip_pkg::cfg_t           cfg,
	input  logic                     q_valid,
	input  ttip_pkg::chr_class_t     q_head,
	output logic                     q_pop,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [63:0]              res_value,
	output logic [OFFSET_WIDTH-1:0]  res_offset,
	output logic [1:0]               res_status
);

	// parser state
	ttip_pkg::phase_t        phase_q;
	logic                    neg_q;
	logic [63:0]             acc_q;
	logic [5:0]              base_q;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic                    seen_q;
	logic                    ovf_q;
	logic [1:0]              kind_q;
	logic [OFFSET_WIDTH-1:0] mark_q;

	// state as seen by this beat, after a begin has reloaded it
	ttip_pkg::phase_t        ph_b;
	logic                    neg_b;
	logic [63:0]             acc_b;
	logic [5:0]              base_b;
	logic [OFFSET_WIDTH-1:0] pos_b;
	logic                    seen_b;
	logic                    ovf_b;
	logic [1:0]              kind_b;
	logic [OFFSET_WIDTH-1:0] mark_b;
	logic                    bad_base;

	// step decision
	ttip_pkg::phase_t        ph_n;
	ttip_pkg::act_t          act;
	logic [5:0]              base_r;

	// datapath results
	logic                    neg_n;
	logic [63:0]             acc_n;
	logic [5:0]              base_n;
	logic [OFFSET_WIDTH-1:0] pos_n;
	logic [OFFSET_WIDTH-1:0] pos_inc;
	logic                    seen_n;
	logic                    ovf_n;
	logic [OFFSET_WIDTH-1:0] mark_n;
	logic [63:0]             lim;
	logic [70:0]             mac;
	logic                    emit;
	logic [63:0]             e_value;
	logic [OFFSET_WIDTH-1:0] e_offset;
	logic [1:0]              e_status;
	logic [63:0]             sat_value;
	logic [63:0]             ok_value;

	logic                    out_valid_q;
	logic [63:0]             out_value_q;
	logic [OFFSET_WIDTH-1:0] out_offset_q;
	logic [1:0]              out_status_q;

	assign q_pop = q_valid && (!out_valid_q || res_ready);

	// reload on begin
	always_comb begin
		bad_base = (cfg.radix == ttip_pkg::BASE_ONE) || (cfg.radix > ttip_pkg::MAX_BASE);
		if (q_head.begin_req) begin
			ph_b   = ttip_pkg::PH_LEAD;
			neg_b  = 1'b0;
			acc_b  = '0;
			base_b = cfg.radix;
			pos_b  = '0;
			seen_b = 1'b0;
			ovf_b  = 1'b0;
			kind_b = cfg.kind;
			mark_b = '0;
		end else begin
			ph_b   = phase_q;
			neg_b  = neg_q;
			acc_b  = acc_q;
			base_b = base_q;
			pos_b  = pos_q;
			seen_b = seen_q;
			ovf_b  = ovf_q;
			kind_b = kind_q;
			mark_b = mark_q;
		end
	end

	// next phase and action; phases fall through as the character moves on
	always_comb begin
		ttip_pkg::phase_t cur;
		logic             done;
		logic             pfx_base;
		cur      = ph_b;
		done     = 1'b0;
		ph_n     = ph_b;
		act      = ttip_pkg::ACT_IGNORE;
		base_r   = base_b;
		pfx_base = (base_b == ttip_pkg::BASE_AUTO) || (base_b == ttip_pkg::BASE_HEX);
		if (q_head.begin_req && bad_base) begin
			act  = ttip_pkg::ACT_BAD_BASE;
			ph_n = ttip_pkg::PH_DONE;
			done = 1'b1;
		end
		if (!done && cur == ttip_pkg::PH_LEAD) begin
			if (q_head.space) begin
				act  = ttip_pkg::ACT_ADVANCE;
				done = 1'b1;
			end else if (q_head.plus || q_head.minus) begin
				act  = ttip_pkg::ACT_SIGN;
				ph_n = ttip_pkg::PH_SIGNED;
				done = 1'b1;
			end else begin
				cur = ttip_pkg::PH_SIGNED;
			end
		end
		if (!done && cur == ttip_pkg::PH_SIGNED) begin
			if (q_head.digit == ttip_pkg::DIGIT_ZERO && pfx_base) begin
				act  = ttip_pkg::ACT_ZERO;
				ph_n = ttip_pkg::PH_ZERO;
				done = 1'b1;
			end else begin
				if (base_b == ttip_pkg::BASE_AUTO) base_r = ttip_pkg::BASE_DEC;
				cur = ttip_pkg::PH_DIGITS;
			end
		end else if (!done && cur == ttip_pkg::PH_ZERO) begin
			if (q_head.digit == ttip_pkg::DIGIT_X && pfx_base) begin
				act    = ttip_pkg::ACT_PREFIX;
				ph_n   = ttip_pkg::PH_AFTERX;
				base_r = ttip_pkg::BASE_HEX;
				done   = 1'b1;
			end else begin
				if (base_b == ttip_pkg::BASE_AUTO) base_r = ttip_pkg::BASE_OCT;
				cur = ttip_pkg::PH_DIGITS;
			end
		end else if (!done && cur == ttip_pkg::PH_AFTERX) begin
			if (q_head.digit >= ttip_pkg::BASE_HEX) begin
				act  = ttip_pkg::ACT_FIN_MARK;
				ph_n = ttip_pkg::PH_DONE;
				done = 1'b1;
			end else begin
				cur = ttip_pkg::PH_DIGITS;
			end
		end
		if (!done && cur == ttip_pkg::PH_DIGITS) begin
			if (base_r >= 6'd2 && q_head.digit < base_r) begin
				act  = ttip_pkg::ACT_DIGIT;
				ph_n = ttip_pkg::PH_DIGITS;
			end else begin
				act  = ttip_pkg::ACT_FIN_POS;
				ph_n = ttip_pkg::PH_DONE;
			end
		end
	end

	// limit and saturation value of the latched kind
	always_comb begin
		priority if (kind_b == ttip_pkg::KIND_U32) begin
			lim = ttip_pkg::LIM_U32;
		end else if (kind_b == ttip_pkg::KIND_S64) begin
			lim = neg_b ? ttip_pkg::MIN_S64 : ttip_pkg::LIM_S64;
		end else begin
			lim = ttip_pkg::LIM_U64;
		end
		sat_value = lim;
		ok_value  = neg_b ? (64'd0 - acc_b) : acc_b;
		if (kind_b == ttip_pkg::KIND_U32) ok_value = {32'd0, ok_value[31:0]};
	end

	// multiply-add by the base; overflow when it would pass the limit
	assign mac     = 71'(acc_b) * 71'(base_r) + 71'(q_head.digit);
	assign pos_inc = (&pos_b) ? pos_b : pos_b + 1'b1;

	// datapath and result
	always_comb begin
		neg_n    = neg_b;
		acc_n    = acc_b;
		base_n   = base_r;
		pos_n    = pos_b;
		seen_n   = seen_b;
		ovf_n    = ovf_b;
		mark_n   = mark_b;
		emit     = 1'b0;
		e_value  = '0;
		e_offset = '0;
		e_status = ttip_pkg::ST_OK;
		unique case (act)
			ttip_pkg::ACT_IGNORE: begin
			end
			ttip_pkg::ACT_ADVANCE: begin
				pos_n = pos_inc;
			end
			ttip_pkg::ACT_SIGN: begin
				neg_n = q_head.minus;
				pos_n = pos_inc;
			end
			ttip_pkg::ACT_ZERO: begin
				seen_n = 1'b1;
				acc_n  = '0;
				pos_n  = pos_inc;
			end
			ttip_pkg::ACT_PREFIX: begin
				mark_n = pos_b;
				pos_n  = pos_inc;
			end
			ttip_pkg::ACT_DIGIT: begin
				seen_n = 1'b1;
				pos_n  = pos_inc;
				if (!ovf_b) begin
					if (mac > 71'(lim)) ovf_n = 1'b1;
					else acc_n = mac[63:0];
				end
			end
			ttip_pkg::ACT_FIN_POS, ttip_pkg::ACT_FIN_MARK: begin
				emit = 1'b1;
				if (!seen_b) begin
					e_status = ttip_pkg::ST_NO_DIGITS;
				end else begin
					e_offset = (act == ttip_pkg::ACT_FIN_MARK) ? mark_b : pos_b;
					e_value  = ovf_b ? sat_value : ok_value;
					e_status = ovf_b ? ttip_pkg::ST_OVERFLOW : ttip_pkg::ST_OK;
				end
			end
			ttip_pkg::ACT_BAD_BASE: begin
				emit     = 1'b1;
				e_status = ttip_pkg::ST_BAD_BASE;
			end
			default: begin
			end
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ttip_pkg::PH_DONE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			base_q  <= '0;
			pos_q   <= '0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
			kind_q  <= '0;
			mark_q  <= '0;
		end else if (q_pop) begin
			phase_q <= ph_n;
			neg_q   <= neg_n;
			acc_q   <= acc_n;
			base_q  <= base_n;
			pos_q   <= pos_n;
			seen_q  <= seen_n;
			ovf_q   <= ovf_n;
			kind_q  <= kind_b;
			mark_q  <= mark_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_value_q  <= e_value;
			out_offset_q <= e_offset;
			out_status_q <= e_status;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_value  = out_value_q;
	assign res_offset = out_offset_q;
	assign res_status = out_status_q;

endmodule

// ===== hw/rtl/text_to_integer_parser_unit.sv =====
// ----------------------------------------------------------------------------
// text_to_integer_parser_unit - streaming strtoul / strtoull / strtoll parser
// Classifier, two-entry queue, parser back end and configuration registers.
//
//   channel  | signals                                  | beat
//   ---------+------------------------------------------+-------------------
//   item     | item_valid, item_ready, begin_req, chr   | one character
//   result   | result_valid, result_ready, value,       | one parsed number
//            | end_offset, status                       |
//   config   | wr_en, wr_index, wr_data                 | one register write
//
// One character beat per cycle sustained while results are taken; the rate is
// set by the 64-bit multiply-add by the base in the back end, which closes on itself.
// A result is registered once the back end pops the beat that ends the number.
// Reset clears control state at once; there is no clearing pass.
// A stalled result register stops the back end; the queue keeps taking
// beats until it holds two.
// ----------------------------------------------------------------------------
module text_to_integer_parser_unit #(
	parameter int OFFSET_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic                    begin_req,
	input  logic [7:0]              chr,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [63:0]             value,
	output logic [OFFSET_WIDTH-1:0] end_offset,
	output logic [1:0]              status,
	input  logic                    wr_en,
	input  logic                    wr_index,
	input  logic [5:0]              wr_data
);

	ttip_pkg::cfg_t       cfg_q;
	ttip_pkg::chr_class_t cls;
	ttip_pkg::chr_class_t q_head;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_pop;
	logic                 push;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix <= ttip_pkg::RADIX_RESET;
			cfg_q.kind  <= ttip_pkg::KIND_U32;
		end else if (wr_en) begin
			unique case (wr_index)
				ttip_pkg::REG_RADIX: cfg_q.radix <= wr_data;
				ttip_pkg::REG_KIND:  cfg_q.kind  <= wr_data[1:0];
				default: begin
				end
			endcase
		end
	end

	assign item_ready = !q_full;
	assign push       = item_valid && !q_full;

	ttip_front u_front (
		.begin_req (begin_req),
		.chr       (chr),
		.cls       (cls)
	);

	ttip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	ttip_back #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.res_valid  (result_valid),
		.res_ready  (result_ready),
		.res_value  (value),
		.res_offset (end_offset),
		.res_status (status)
	);

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - text_to_integer_parser_unit
// A predictor tracks the parser state beat by beat and queues the expected
// numbers. A directed part covers the special cases: whitespace, signs,
// prefixes, restarts, bad bases and overflow. Random strings follow under
// three idling profiles, with config changes while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] KIND_ALT64 = 2'd3;	// behaves like unsigned 64-bit
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam int         LONG_HOLD  = 400;
	localparam int         TIMEOUT_NS = 20_000_000;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] offset;
		logic [1:0]  status;
	} number_t;

	typedef struct packed {
		logic       lead;
		logic [7:0] ch;
	} beat_t;

	// DUT ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        begin_req = 1'b0;
	logic [7:0]  chr = 8'h00;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [63:0] value;
	logic [15:0] end_offset;
	logic [1:0]  status;
	logic        wr_en = 1'b0;
	logic        wr_index = ttip_pkg::REG_RADIX;
	logic [5:0]  wr_data = 6'd0;

	// idling profile and receiver hold-off requests
	int send_idle = 13;
	int recv_idle = 76;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;

	beat_t line[$];

	function automatic int char_digit(logic [7:0] c);
		if (c >= ttip_pkg::CH_0 && c <= ttip_pkg::CH_9) return c - ttip_pkg::CH_0;
		if (c >= ttip_pkg::CH_UA && c <= ttip_pkg::CH_UZ)
			return c - ttip_pkg::CH_UA + ttip_pkg::ALPHA_OFS;
		if (c >= ttip_pkg::CH_LA && c <= ttip_pkg::CH_LZ)
			return c - ttip_pkg::CH_LA + ttip_pkg::ALPHA_OFS;
		return int'(ttip_pkg::DIGIT_NONE);
	endfunction

	// ------------------------------------------------------------------------
	// predictor and store of expected numbers
	// ------------------------------------------------------------------------
	class number_scoreboard;
		logic [5:0]        radix;
		logic [1:0]        kind_sel;
		ttip_pkg::phase_t  phase;
		bit                negative;
		bit                seen;
		bit                overflowed;
		logic [63:0]       acc;
		logic [5:0]        base;
		logic [1:0]        kind;
		logic [15:0]       pos;
		logic [15:0]       mark;
		number_t           numbers_due[$];
		int                errors;
		int                live_beats;

		function new();
			radix = ttip_pkg::RADIX_RESET;
			kind_sel = ttip_pkg::KIND_U32;
			phase = ttip_pkg::PH_DONE;
			negative = 0;
			seen = 0;
			overflowed = 0;
			acc = '0;
			base = '0;
			kind = ttip_pkg::KIND_U32;
			pos = '0;
			mark = '0;
			errors = 0;
			live_beats = 0;
		endfunction

		function void load_config(logic [5:0] rad, logic [1:0] knd);
			radix = rad;
			kind_sel = knd;
		endfunction

		function void bump();
			if (pos != 16'hFFFF) pos++;
		endfunction

		// saturation bound of the latched kind
		function logic [63:0] limit();
			if (kind == ttip_pkg::KIND_U32) return ttip_pkg::LIM_U32;
			if (kind == ttip_pkg::KIND_S64)
				return negative ? ttip_pkg::MIN_S64 : ttip_pkg::LIM_S64;
			return ttip_pkg::LIM_U64;
		endfunction

		function void close_number(logic [15:0] off);
			number_t n;
			if (!seen) begin
				n = '{64'd0, 16'd0, ttip_pkg::ST_NO_DIGITS};
			end else if (overflowed) begin
				n = '{limit(), off, ttip_pkg::ST_OVERFLOW};
			end else begin
				n = '{negative ? -acc : acc, off, ttip_pkg::ST_OK};
				if (kind == ttip_pkg::KIND_U32) n.value[63:32] = '0;
			end
			numbers_due.push_back(n);
			phase = ttip_pkg::PH_DONE;
		endfunction

		// one accepted character beat
		function void parse_char(logic lead, logic [7:0] c);
			int d;
			logic [63:0] dd;
			logic [63:0] b;
			if (lead) begin
				base = radix;
				kind = kind_sel;
				negative = 0;
				acc = '0;
				pos = '0;
				seen = 0;
				overflowed = 0;
				mark = '0;
				if (base == ttip_pkg::BASE_ONE || base > ttip_pkg::MAX_BASE) begin
					numbers_due.push_back('{64'd0, 16'd0, ttip_pkg::ST_BAD_BASE});
					phase = ttip_pkg::PH_DONE;
					live_beats++;
					return;
				end
				phase = ttip_pkg::PH_LEAD;
			end
			if (phase == ttip_pkg::PH_DONE) return;
			live_beats++;

			// leading whitespace and sign
			if (phase == ttip_pkg::PH_LEAD) begin
				if (c == ttip_pkg::CH_SPACE || (c >= ttip_pkg::CH_TAB && c <= ttip_pkg::CH_CR)) begin
					bump();
					return;
				end
				if (c == ttip_pkg::CH_MINUS || c == ttip_pkg::CH_PLUS) begin
					negative = (c == ttip_pkg::CH_MINUS);
					bump();
					phase = ttip_pkg::PH_SIGNED;
					return;
				end
				phase = ttip_pkg::PH_SIGNED;
			end

			// prefix handling and automatic base
			if (phase == ttip_pkg::PH_SIGNED) begin
				if (c == ttip_pkg::CH_0 &&
				    (base == ttip_pkg::BASE_AUTO || base == ttip_pkg::BASE_HEX)) begin
					seen = 1;
					acc = '0;
					bump();
					phase = ttip_pkg::PH_ZERO;
					return;
				end
				if (base == ttip_pkg::BASE_AUTO) base = ttip_pkg::BASE_DEC;
				phase = ttip_pkg::PH_DIGITS;
			end else if (phase == ttip_pkg::PH_ZERO) begin
				if ((c == "x" || c == "X") &&
				    (base == ttip_pkg::BASE_AUTO || base == ttip_pkg::BASE_HEX)) begin
					base = ttip_pkg::BASE_HEX;
					mark = pos;
					bump();
					phase = ttip_pkg::PH_AFTERX;
					return;
				end
				if (base == ttip_pkg::BASE_AUTO) base = ttip_pkg::BASE_OCT;
				phase = ttip_pkg::PH_DIGITS;
			end else if (phase == ttip_pkg::PH_AFTERX) begin
				// bare prefix ends just after the zero
				if (char_digit(c) >= 16) begin
					close_number(mark);
					return;
				end
				phase = ttip_pkg::PH_DIGITS;
			end

			// digit accumulation, saturating on overflow
			d = char_digit(c);
			if (base >= 2 && d < base) begin
				seen = 1;
				bump();
				if (!overflowed) begin
					dd = 64'(d);
					b = 64'(base);
					if (acc > (limit() - dd) / b) overflowed = 1;
					else acc = acc * b + dd;
				end
				return;
			end
			close_number(pos);
		endfunction

		function void check_number(logic [63:0] v, logic [15:0] off, logic [1:0] st);
			number_t want;
			if (numbers_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with nothing pending: value %h offset %0d status %0d",
						$realtime, v, off, st);
				return;
			end
			want = numbers_due.pop_front();
			if (want.value !== v || want.offset !== off || want.status !== st) begin
				errors++;
				if (errors <= 10)
					$display("%0t: wrong result: value %h/%h offset %0d/%0d status %0d/%0d %s",
						$realtime, want.value, v, want.offset, off, want.status, st,
						"(expected/got)");
			end
		endfunction
	endclass

	number_scoreboard board = new();

	text_to_integer_parser_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.begin_req    (begin_req),
		.chr          (chr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.end_offset   (end_offset),
		.status       (status),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always #6 clk = ~clk;

	// result side: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (hold_done != hold_asked) begin
			hold_done <= hold_asked;
			hold_left <= LONG_HOLD;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// beat monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) board.parse_char(begin_req, chr);
			if (result_valid && result_ready) board.check_number(value, end_offset, status);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic void add(logic lead, logic [7:0] c);
		line.push_back('{lead, c});
	endfunction

	function automatic void add_text(logic lead, string s);
		for (int i = 0; i < s.len(); i++) add(lead && i == 0, s[i]);
	endfunction

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) return ttip_pkg::CH_0 + 8'(d);
		return ($urandom_range(1) ? ttip_pkg::CH_UA : ttip_pkg::CH_LA) + 8'(d) -
			ttip_pkg::ALPHA_OFS;
	endfunction

	// number: blanks, sign, prefix, digits (at times none after a prefix), terminator
	function automatic void add_number(logic [5:0] rad);
		int base;
		int start;
		int n;
		int k;
		bit prefixed;
		logic [63:0] v;
		int digs[$];
		start = line.size();
		prefixed = 0;
		base = (rad == ttip_pkg::BASE_AUTO || rad == ttip_pkg::BASE_ONE ||
			rad > ttip_pkg::MAX_BASE) ? 10 : int'(rad);
		repeat ($urandom_range(0, 2)) begin
			k = $urandom_range(0, 5);
			add(1'b0, k == 5 ? ttip_pkg::CH_SPACE : ttip_pkg::CH_TAB + 8'(k));
		end
		case ($urandom_range(0, 3))
			0: add(1'b0, ttip_pkg::CH_MINUS);
			1: add(1'b0, ttip_pkg::CH_PLUS);
			default: ;
		endcase
		if (rad == ttip_pkg::BASE_AUTO || rad == ttip_pkg::BASE_HEX) begin
			k = $urandom_range(0, 2);
			if (k == 0) begin
				add(1'b0, ttip_pkg::CH_0);
				add(1'b0, $urandom_range(1) ? "x" : "X");
				base = 16;
				prefixed = 1;
			end else if (k == 1 && rad == ttip_pkg::BASE_AUTO) begin
				add(1'b0, ttip_pkg::CH_0);
				base = 8;
			end
		end
		if (!(prefixed && $urandom_range(0, 9) == 0)) begin
			k = $urandom_range(0, 4);
			if (k == 0) begin
				// values at the saturation bounds, sometimes one digit past
				case ($urandom_range(0, 5))
					0: v = ttip_pkg::LIM_U32;
					1: v = ttip_pkg::LIM_U32 + 1;
					2: v = ttip_pkg::LIM_S64;
					3: v = ttip_pkg::MIN_S64;
					4: v = ttip_pkg::MIN_S64 + 1;
					default: v = ttip_pkg::LIM_U64;
				endcase
				v -= $urandom_range(0, 1);
				while (v != 0) begin
					digs.push_front(int'(v % base));
					v /= base;
				end
				if ($urandom_range(1)) digs.push_back($urandom_range(0, base - 1));
			end else begin
				n = $urandom_range(1, k == 1 ? 70 : 12);
				repeat (n) digs.push_back($urandom_range(0, base - 1));
				if (rad == ttip_pkg::BASE_AUTO && base == 10) digs[0] = $urandom_range(1, 9);
			end
			foreach (digs[i]) add(1'b0, digit_char(digs[i]));
		end
		if ($urandom_range(1)) begin
			add(1'b0, CH_NUL);
		end else begin
			do k = $urandom_range(0, 255); while (char_digit(8'(k)) < base);
			add(1'b0, 8'(k));
		end
		line[start].lead = 1'b1;
	endfunction

	function automatic void add_noise();
		int n;
		logic [7:0] c;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: c = ttip_pkg::CH_0;
				1: c = "x";
				2: c = ttip_pkg::CH_MINUS;
				3: c = ttip_pkg::CH_SPACE;
				4, 5: c = digit_char($urandom_range(0, 35));
				default: c = 8'($urandom_range(0, 255));
			endcase
			add(i == 0 || $urandom_range(0, 9) == 0, c);
		end
	endfunction

	task automatic send_line();
		foreach (line[i]) begin
			while ($urandom_range(99) < send_idle) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
			item_valid <= 1'b1;
			begin_req <= line[i].lead;
			chr <= line[i].ch;
			@(posedge clk);
			while (!item_ready) @(posedge clk);
		end
		line.delete();
	endtask

	// sender pauses until every pending number has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.numbers_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic [5:0] rad, logic [1:0] knd);
		wr_en <= 1'b1;
		wr_index <= ttip_pkg::REG_RADIX;
		wr_data <= rad;
		@(posedge clk);
		wr_index <= ttip_pkg::REG_KIND;
		wr_data <= {4'($urandom_range(15)), knd};
		@(posedge clk);
		wr_en <= 1'b0;
		board.load_config(rad, knd);
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int target;
		int cut;
		logic [5:0] rad;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored before any begin, all blanks, idle after result, restart
		add_text(1'b0, "5");
		add_text(1'b1, "\011\012\013\014\015 -7");
		add(1'b0, CH_NUL);
		add(1'b0, 8'hFF);
		add_text(1'b1, "12");
		add_text(1'b1, "+9");
		add(1'b0, 8'hFF);
		send_line();
		wait_drained();

		// automatic base: bare prefix, hex, octal, decimal
		set_config(ttip_pkg::BASE_AUTO, ttip_pkg::KIND_S64);
		add_text(1'b1, "0xg");
		add_text(1'b1, "0X1f");
		add(1'b0, CH_NUL);
		add_text(1'b1, "017 ");
		add_text(1'b1, "-9");
		add(1'b0, CH_NUL);
		send_line();
		wait_drained();

		// invalid bases, rest of the string ignored
		set_config(ttip_pkg::BASE_ONE, ttip_pkg::KIND_U64);
		add_text(1'b1, "x1");
		send_line();
		wait_drained();
		set_config(6'd63, KIND_ALT64);
		add_text(1'b1, "7");
		send_line();
		wait_drained();

		// no digits, then overflow in base 36
		set_config(ttip_pkg::MAX_BASE, KIND_ALT64);
		add_text(1'b1, "-!");
		add_text(1'b1, "-ZZZZZZZZZZZZZ");
		add(1'b0, CH_NUL);
		send_line();
		wait_drained();

		set_config(6'd2, ttip_pkg::KIND_U32);
		add_text(1'b1, "101");
		add(1'b0, CH_NUL);
		send_line();
		wait_drained();

		// random strings under three idling profiles
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle = 13;
					recv_idle <= 76;
				end
				1: begin
					send_idle = 76;
					recv_idle <= 13;
				end
				default: begin
					send_idle = 0;
					recv_idle <= 0;
				end
			endcase
			hold_asked <= hold_asked + 1;
			target = board.live_beats + 380;
			while (board.live_beats < target) begin
				wait_drained();
				case ($urandom_range(0, 9))
					0, 1: rad = ttip_pkg::BASE_AUTO;
					2: rad = ttip_pkg::BASE_HEX;
					3: rad = $urandom_range(1) ? ttip_pkg::BASE_ONE : 6'($urandom_range(37, 63));
					default: rad = 6'($urandom_range(2, 36));
				endcase
				set_config(rad, 2'($urandom_range(0, 3)));
				repeat (6) begin
					case ($urandom_range(0, 9))
						0: add_noise();
						1: begin
							// truncated number, dropped by the next begin
							cut = line.size();
							add_number(rad);
							cut = $urandom_range(cut + 1, line.size() - 1);
							while (line.size() > cut) void'(line.pop_back());
						end
						default: begin
							add_number(rad);
							if ($urandom_range(0, 4) == 0) add(1'b0, 8'($urandom_range(0, 255)));
						end
					endcase
				end
				send_line();
			end
		end

		wait_drained();
		repeat (12) @(posedge clk);
		if (board.errors == 0 && board.numbers_due.size() == 0)
			$display("text_to_integer_parser_unit: match");
		else
			$display("text_to_integer_parser_unit: mismatch");
		$finish;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("text_to_integer_parser_unit: mismatch");
		$finish;
	end

endmodule
